@@ sv/bfi_pkg.sv @@
`timescale 1ns / 1ps

package bfi_pkg;

    localparam int TAPE_CELLS = 2048;
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_AW    = $clog2(TAPE_CELLS);
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int PC_W       = PROG_AW + 1;

    localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
    localparam logic [PC_W-1:0]    PROG_FULL = PC_W'(PROG_DEPTH);

    // request modes (s_tuser)
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    // command characters
    localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
    localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_POST
    } bfi_state_t;

    typedef struct packed {
        logic accept;   // request taken this cycle
        logic init;     // reset-mode request: clear registers
        logic load;     // append s_tdata to program store
        logic clr_wr;   // tape clearing sweep write
        logic exec;     // decode and execute fetched instruction
        logic scan;     // one bracket-scan byte
        logic post;     // load the output register
    } bfi_cmd_t;

    typedef struct packed {
        logic clr_last;  // sweep at last cell
        logic fault;
        logic done;      // pc >= program length
        logic scan_go;   // executed bracket needs a scan
        logic scan_end;  // scan found match or failed
        logic out_free;  // output register can take a result
    } bfi_stat_t;

endpackage

@@ sv/bfi_ctrl.sv @@
`timescale 1ns / 1ps

module bfi_ctrl
    import bfi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_mode,
    output logic       s_tready,
    input  bfi_stat_t  stat,
    output bfi_cmd_t   cmd
);

    bfi_state_t state_reg, state_next;
    logic       clr_item_reg, clr_item_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_POST) && stat.out_free);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_item_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_item_reg <= clr_item_next;
        end
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        clr_item_next = clr_item_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next    = clr_item_reg ? ST_POST : ST_IDLE;
                    clr_item_next = 1'b0;
                end
            end
            ST_IDLE, ST_POST: begin
                if (accept) begin
                    case (s_mode)
                        MODE_RESET: begin
                            state_next    = ST_CLEAR;
                            clr_item_next = 1'b1;
                        end
                        MODE_STEP: begin
                            state_next = (!stat.fault && !stat.done) ? ST_EXEC : ST_POST;
                        end
                        default: state_next = ST_POST;
                    endcase
                end else if (state_reg == ST_POST && stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC: state_next = stat.scan_go ? ST_SCAN : ST_POST;
            ST_SCAN: begin
                if (stat.scan_end) begin
                    state_next = ST_POST;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd        = '0;
        cmd.accept = accept;
        cmd.init   = accept && (s_mode == MODE_RESET);
        cmd.load   = accept && (s_mode == MODE_LOAD);
        cmd.clr_wr = (state_reg == ST_CLEAR);
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.post   = (state_reg == ST_POST) && stat.out_free;
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !cmd.accept)
        else $error("request accepted during tape clear");

    a_exec_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> (state_reg == ST_SCAN || state_reg == ST_POST))
        else $error("execute did not move to scan or post");

    a_reset_req_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init |=> (state_reg == ST_CLEAR && clr_item_reg))
        else $error("reset request did not start clear sweep");

endmodule

@@ sv/bfi_dpath.sv @@
`timescale 1ns / 1ps

module bfi_dpath
    import bfi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_byte,
    input  bfi_cmd_t   cmd,
    output bfi_stat_t  stat,
    input  logic       m_tready,
    output logic       m_tvalid,
    output logic       m_emit,
    output logic [7:0] m_byte,
    output logic       m_done,
    output logic       m_fault
);

    logic [7:0] tape_mem [TAPE_CELLS];
    logic [7:0] prog_mem [PROG_DEPTH];

    logic [7:0]         tape_rdata_reg, prog_rdata_reg;
    logic [PC_W-1:0]    len_reg, len_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [TAPE_AW-1:0] dp_reg, dp_next;
    logic               fault_reg, fault_next;
    logic [TAPE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PC_W-1:0]    j_reg, j_next;
    logic [PC_W-1:0]    depth_reg, depth_next;
    logic               fwd_reg, fwd_next;
    logic               emit_reg, emit_next;
    logic [7:0]         val_reg, val_next;
    logic               m_valid_reg, m_emit_reg, m_done_reg, m_fault_reg;
    logic [7:0]         m_byte_reg;

    logic [7:0]         op, tape_val;
    logic               done, out_free;
    logic               scan_need;
    logic [PC_W-1:0]    j_cur, j_adv, depth_upd;
    logic               dir_fwd, bound_fail, found;
    logic               tape_we;
    logic [TAPE_AW-1:0] tape_waddr;
    logic [7:0]         tape_wdata;
    logic [PROG_AW-1:0] prog_raddr;

    assign op       = prog_rdata_reg;
    assign tape_val = tape_rdata_reg;
    assign done     = (pc_reg >= len_reg);
    assign out_free = !m_valid_reg || m_tready;

    assign scan_need = ((op == OP_OPEN) && (tape_val == 8'd0)) ||
                       ((op == OP_CLOSE) && (tape_val != 8'd0));

    // scan walker, shared by the first bracket step and the scan loop
    assign j_cur   = cmd.exec ? pc_reg : j_reg;
    assign dir_fwd = cmd.exec ? (op == OP_OPEN) : fwd_reg;

    always_comb begin
        depth_upd = depth_reg;
        if (op == OP_OPEN) begin
            depth_upd = fwd_reg ? depth_reg + 1'b1 : depth_reg - 1'b1;
        end else if (op == OP_CLOSE) begin
            depth_upd = fwd_reg ? depth_reg - 1'b1 : depth_reg + 1'b1;
        end
    end

    assign found = cmd.scan && (depth_upd == '0);

    always_comb begin
        if (dir_fwd) begin
            j_adv      = j_cur + 1'b1;
            bound_fail = (j_adv >= len_reg);
        end else begin
            j_adv      = j_cur - 1'b1;
            bound_fail = (j_cur == '0);
        end
    end

    assign prog_raddr = (cmd.exec || cmd.scan) ? j_adv[PROG_AW-1:0] : pc_reg[PROG_AW-1:0];

    always_comb begin
        stat          = '0;
        stat.clr_last = (clr_cnt_reg == TAPE_LAST);
        stat.fault    = fault_reg;
        stat.done     = done;
        stat.scan_go  = scan_need && !bound_fail;
        stat.scan_end = found || bound_fail;
        stat.out_free = out_free;
    end

    // tape write port: clear sweep or read-modify-write
    always_comb begin
        tape_we    = cmd.clr_wr || (cmd.exec && (op == OP_INC || op == OP_DEC));
        tape_waddr = cmd.clr_wr ? clr_cnt_reg : dp_reg;
        if (cmd.clr_wr) begin
            tape_wdata = 8'd0;
        end else if (op == OP_INC) begin
            tape_wdata = tape_val + 8'd1;
        end else begin
            tape_wdata = tape_val - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata_reg <= tape_mem[dp_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && (len_reg < PROG_FULL)) begin
            prog_mem[len_reg[PROG_AW-1:0]] <= s_byte;
        end
        prog_rdata_reg <= prog_mem[prog_raddr];
    end

    always_comb begin
        len_next     = len_reg;
        pc_next      = pc_reg;
        dp_next      = dp_reg;
        fault_next   = fault_reg;
        clr_cnt_next = clr_cnt_reg;
        j_next       = j_reg;
        depth_next   = depth_reg;
        fwd_next     = fwd_reg;
        emit_next    = emit_reg;
        val_next     = val_reg;

        if (cmd.accept) begin
            emit_next = 1'b0;
        end
        if (cmd.init) begin
            len_next     = '0;
            pc_next      = '0;
            dp_next      = '0;
            fault_next   = 1'b0;
            clr_cnt_next = '0;
        end
        if (cmd.load) begin
            if (len_reg < PROG_FULL) begin
                len_next = len_reg + 1'b1;
            end else begin
                fault_next = 1'b1;
            end
        end
        if (cmd.clr_wr) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.exec) begin
            case (op)
                OP_RIGHT: begin
                    if (dp_reg == TAPE_LAST) begin
                        fault_next = 1'b1;
                    end else begin
                        dp_next = dp_reg + 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                end
                OP_LEFT: begin
                    if (dp_reg == '0) begin
                        fault_next = 1'b1;
                    end else begin
                        dp_next = dp_reg - 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                end
                OP_OUT: begin
                    emit_next = 1'b1;
                    val_next  = tape_val;
                    pc_next   = pc_reg + 1'b1;
                end
                OP_OPEN, OP_CLOSE: begin
                    if (!scan_need) begin
                        pc_next = pc_reg + 1'b1;
                    end else if (bound_fail) begin
                        fault_next = 1'b1;
                    end else begin
                        j_next     = j_adv;
                        depth_next = PC_W'(1);
                        fwd_next   = (op == OP_OPEN);
                    end
                end
                default: pc_next = pc_reg + 1'b1;
            endcase
        end
        if (cmd.scan) begin
            if (found) begin
                pc_next = j_reg + 1'b1;
            end else if (bound_fail) begin
                fault_next = 1'b1;
            end else begin
                j_next     = j_adv;
                depth_next = depth_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pc_reg      <= '0;
            dp_reg      <= '0;
            fault_reg   <= 1'b0;
            clr_cnt_reg <= '0;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            pc_reg      <= pc_next;
            dp_reg      <= dp_next;
            fault_reg   <= fault_next;
            clr_cnt_reg <= clr_cnt_next;
            emit_reg    <= emit_next;
            if (cmd.post) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        j_reg     <= j_next;
        depth_reg <= depth_next;
        fwd_reg   <= fwd_next;
        val_reg   <= val_next;
        if (cmd.post) begin
            m_emit_reg  <= emit_reg;
            m_byte_reg  <= emit_reg ? val_reg : 8'd0;
            m_done_reg  <= done;
            m_fault_reg <= fault_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_emit   = m_emit_reg;
    assign m_byte   = m_byte_reg;
    assign m_done   = m_done_reg;
    assign m_fault  = m_fault_reg;

    a_pc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= len_reg)
        else $error("program counter beyond program length");

    a_len_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= PROG_FULL)
        else $error("program length beyond store depth");

endmodule

@@ sv/brainfuck_interpreter_core.sv @@
`timescale 1ns / 1ps
// Accept to m_tvalid: load, unused-mode and no-op steps (finished or faulted machine) go
//   to POST; an executed step runs EXEC, then SCAN per scanned byte, then POST.
// A reset-mode request sweeps the tape one cell a cycle, then posts its result.
// Throughput: a request is taken as a result posts; loads 1 per cycle if output is free.
// aresetn (sync, active low) clears control state, then a tape sweep over every cell
// runs with s_tready low; it produces no result.

module brainfuck_interpreter_core
    import bfi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] program_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] done_res, [9] fault, rest zero
    output logic [0:0]  m_tuser    // [0] out_valid
);

    bfi_cmd_t  cmd;
    bfi_stat_t stat;

    logic       res_emit;
    logic [7:0] res_byte;
    logic       res_done;
    logic       res_fault;

    // controller: sequences accept, clear sweep, execute, scan and post
    bfi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: tape and program memories, pointers, output register
    bfi_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_byte   (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_emit   (res_emit),
        .m_byte   (res_byte),
        .m_done   (res_done),
        .m_fault  (res_fault)
    );

    // result packing, out_byte in the low byte
    assign m_tdata = {6'd0, res_fault, res_done, res_byte};
    assign m_tuser = res_emit;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bfi_pkg::*;

    // mode 3 has no package name: the block must ignore it and only report status
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 400;   // receiver hold-off, cycles
    localparam int         MAX_PRINTS  = 40;

    typedef struct packed {
        logic       emit;    // '.' executed
        logic [7:0] val;
        logic       done;
        logic       fault;
    } step_result_t;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] pbyte;
        int         gap;     // idle cycles before the request is offered
        bit         hold;    // kick the long receiver hold-off when taken
        bit         drain;   // offer only once every result is back
    } bf_req_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] program_byte
    logic [1:0]  s_tuser  = 2'b00;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [8] done_res, [9] fault, rest zero
    logic [0:0]  m_tuser;            // [0] out_valid

    brainfuck_interpreter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Machine image kept by the predictor
    logic [7:0]         tape_img [TAPE_CELLS];
    logic [7:0]         prog_img [PROG_DEPTH];
    logic [PC_W-1:0]    prog_len = '0;
    logic [PC_W-1:0]    prog_ctr = '0;
    logic [TAPE_AW-1:0] data_ptr = '0;
    bit                 faulted  = 1'b0;

    bf_req_t      pending_reqs [$];
    step_result_t results_due  [$];

    int  err_count = 0;
    bit  tx_quiet  = 1'b0;
    bit  rx_quiet  = 1'b0;
    bit  cur_hold  = 1'b0;
    int  gap_spent = 0;
    int  rx_wait   = 0;
    logic hold_kick = 1'b0;
    int  hold_cnt  = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(string what, int got, int want);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic queue_req(logic [1:0] mode, logic [7:0] pbyte);
        bf_req_t r;
        r.mode  = mode;
        r.pbyte = pbyte;
        r.gap   = tx_quiet ? 0 : int'($urandom_range(0, 17));
        r.hold  = 1'b0;
        r.drain = 1'b0;
        pending_reqs.push_back(r);
    endtask

    // Apply one request to the image, return the status the block must report
    function automatic step_result_t apply_request(logic [1:0] mode, logic [7:0] pbyte);
        step_result_t r;
        int          pc, j, depth;
        logic [7:0]  op, tape_val;
        bit          legal;
        r = '0;
        case (mode)
            MODE_RESET: begin
                foreach (tape_img[i]) tape_img[i] = 8'h00;
                prog_len = '0;
                prog_ctr = '0;
                data_ptr = '0;
                faulted  = 1'b0;
            end
            MODE_LOAD: begin
                if (prog_len < PROG_FULL) begin
                    prog_img[prog_len[PROG_AW-1:0]] = pbyte;
                    prog_len = prog_len + 1'b1;
                end else begin
                    faulted = 1'b1;   // store full, byte dropped
                end
            end
            MODE_STEP: begin
                if (!faulted && prog_ctr < prog_len) begin
                    pc       = int'(prog_ctr);
                    op       = prog_img[prog_ctr[PROG_AW-1:0]];
                    tape_val = tape_img[data_ptr];
                    legal    = 1'b1;
                    case (op)
                        OP_RIGHT: if (data_ptr == TAPE_LAST) legal = 1'b0;
                                  else data_ptr = data_ptr + 1'b1;
                        OP_LEFT:  if (data_ptr == '0) legal = 1'b0;
                                  else data_ptr = data_ptr - 1'b1;
                        OP_INC:   tape_img[data_ptr] = tape_val + 8'd1;
                        OP_DEC:   tape_img[data_ptr] = tape_val - 8'd1;
                        OP_OUT: begin
                            r.emit = 1'b1;
                            r.val  = tape_val;
                        end
                        OP_OPEN: if (tape_val == 8'd0) begin
                            depth = 1;
                            j     = pc;
                            while (depth != 0 && legal) begin
                                j++;
                                if (j >= int'(prog_len)) legal = 1'b0;
                                else if (prog_img[PROG_AW'(j)] == OP_OPEN) depth++;
                                else if (prog_img[PROG_AW'(j)] == OP_CLOSE) depth--;
                            end
                            if (legal) pc = j;
                        end
                        OP_CLOSE: if (tape_val != 8'd0) begin
                            depth = 1;
                            j     = pc;
                            while (depth != 0 && legal) begin
                                if (j == 0) begin
                                    legal = 1'b0;
                                end else begin
                                    j--;
                                    if (prog_img[PROG_AW'(j)] == OP_OPEN) depth--;
                                    else if (prog_img[PROG_AW'(j)] == OP_CLOSE) depth++;
                                end
                            end
                            if (legal) pc = j;
                        end
                        default: ;
                    endcase
                    // a fault leaves pc and pointer where they were
                    if (legal) prog_ctr = PC_W'(pc + 1);
                    else       faulted  = 1'b1;
                end
            end
            default: ;
        endcase
        r.done  = (prog_ctr >= prog_len);
        r.fault = faulted;
        return r;
    endfunction

    // Request driver: presents queued requests, predicts each one as it is taken
    always @(posedge aclk) begin : drive
        bf_req_t nxt;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            hold_kick <= 1'b0;
            gap_spent = 0;
        end else begin
            if (s_tvalid && s_tready)
                results_due.push_back(apply_request(s_tuser, s_tdata));
            hold_kick <= s_tvalid && s_tready && cur_hold;
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (gap_spent < pending_reqs[0].gap) begin
                    gap_spent++;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs[0].drain && results_due.size() != 0) begin
                    s_tvalid <= 1'b0;   // pause until the block is empty
                end else begin
                    nxt = pending_reqs.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tuser   <= nxt.mode;
                    s_tdata   <= nxt.pbyte;
                    cur_hold  = nxt.hold;
                    gap_spent = 0;
                end
            end
        end
    end

    // Long receiver hold-off, so the block backs up and stalls its input
    always @(posedge aclk) begin
        if (!aresetn)
            hold_cnt <= 0;
        else if (hold_kick)
            hold_cnt <= LONG_HOLD;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Result monitor: random stalls, compare each result with the oldest prediction
    always @(posedge aclk) begin : watch
        step_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser[0] !== want.emit)
                        flag_mismatch("out_valid", int'(m_tuser[0]), int'(want.emit));
                    if (m_tdata[7:0] !== want.val)
                        flag_mismatch("out_byte", int'(m_tdata[7:0]), int'(want.val));
                    if (m_tdata[8] !== want.done)
                        flag_mismatch("done_res", int'(m_tdata[8]), int'(want.done));
                    if (m_tdata[9] !== want.fault)
                        flag_mismatch("fault", int'(m_tdata[9]), int'(want.fault));
                    if (m_tdata[15:10] !== 6'd0)
                        flag_mismatch("tdata pad", int'(m_tdata[15:10]), 0);
                end
                if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
                rx_wait = rx_quiet ? 0 : int'($urandom_range(0, 17));
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && (hold_cnt == 0) && !hold_kick;
        end
    end

    // Stimulus and end of run
    initial begin
        int         len, open_cnt, pick, nsteps, episode;
        logic [7:0] b;

        // directed: status on empty machine, unused mode
        queue_req(MODE_RESET, 8'h00);
        queue_req(MODE_UNUSED, 8'hFF);
        queue_req(MODE_STEP, 8'h00);
        // wrap below zero, emit 255, wrap back, zero and high skip bytes, then walk off cell 0
        queue_req(MODE_LOAD, OP_DEC);
        queue_req(MODE_LOAD, OP_OUT);
        queue_req(MODE_LOAD, OP_INC);
        queue_req(MODE_LOAD, OP_OUT);
        queue_req(MODE_LOAD, 8'h00);
        queue_req(MODE_LOAD, 8'hFF);
        queue_req(MODE_LOAD, OP_RIGHT);
        queue_req(MODE_LOAD, OP_LEFT);
        queue_req(MODE_LOAD, OP_LEFT);
        repeat (10) queue_req(MODE_STEP, 8'h00);   // last step lands on a faulted machine
        queue_req(MODE_LOAD, OP_INC);              // loads still append while faulted
        // open bracket on a zero cell with no match
        queue_req(MODE_RESET, 8'hA5);
        queue_req(MODE_LOAD, OP_OPEN);
        queue_req(MODE_STEP, 8'h00);
        // close bracket on a nonzero cell with no match
        queue_req(MODE_RESET, 8'h00);
        queue_req(MODE_LOAD, OP_INC);
        queue_req(MODE_LOAD, OP_CLOSE);
        queue_req(MODE_STEP, 8'h00);
        queue_req(MODE_STEP, 8'h00);

        // random programs: mostly balanced brackets, some stray ones and noise
        episode = 0;
        while (pending_reqs.size() < 350) begin
            if ($urandom_range(0, 3) == 0) tx_quiet = ~tx_quiet;
            // now and then keep the old program and append to it
            if (episode == 0 || $urandom_range(0, 4) != 0) begin
                queue_req(MODE_RESET, 8'($urandom));
                if (episode == 0 || $urandom_range(0, 4) == 0)
                    pending_reqs[pending_reqs.size()-1].drain = 1'b1;
            end
            len      = $urandom_range(2, 24);
            open_cnt = 0;
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 15);
                if (pick <= 2)       b = OP_INC;
                else if (pick == 3)  b = OP_DEC;
                else if (pick <= 5)  b = OP_RIGHT;
                else if (pick == 6)  b = OP_LEFT;
                else if (pick <= 8)  b = OP_OUT;
                else if (pick <= 10) begin
                    b = OP_OPEN;
                    open_cnt++;
                end else if (pick <= 12) begin
                    if (open_cnt > 0) begin
                        b = OP_CLOSE;
                        open_cnt--;
                    end else begin
                        b = OP_INC;
                    end
                end else if (pick == 13) b = 8'($urandom);
                else if (pick == 14) begin
                    b = 8'($urandom);
                    queue_req(MODE_UNUSED, b);
                end else if ($urandom_range(0, 3) == 0) b = OP_CLOSE;  // stray close
                else b = OP_INC;
                queue_req(MODE_LOAD, b);
            end
            // leave brackets unclosed once in a while
            if ($urandom_range(0, 6) != 0)
                repeat (open_cnt) queue_req(MODE_LOAD, OP_CLOSE);
            nsteps = len * 3 + $urandom_range(0, 8);
            if (nsteps > 60) nsteps = 60;
            for (int k = 0; k < nsteps; k++) begin
                queue_req(MODE_STEP, 8'($urandom));
                if (k == 0 && (episode == 2 || episode == 5)) begin
                    pending_reqs[pending_reqs.size()-1].hold = 1'b1;
                    tx_quiet = 1'b1;   // keep offering while the receiver holds off
                end
            end
            episode++;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4200) @(posedge aclk);   // longest tape sweep or bracket scan
        if (results_due.size() != 0)
            flag_mismatch("results missing", results_due.size(), 0);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bfi_pkg.sv
sv/bfi_ctrl.sv
sv/bfi_dpath.sv
sv/brainfuck_interpreter_core.sv
tb/tb.sv
